@@ hw/rtl/pmc_pkg.sv @@
// Shared types, constants and the base-pairing function of the palindrome mismatch counter.
package pmc_pkg;

  localparam int unsigned MaxLenDef = 64;

  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChN = 8'h4E;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CMP,
    ST_DONE
  } pmc_state_e;

  function automatic logic [7:0] base_pair(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ChA: r = ChT;
      ChT: r = ChA;
      ChC: r = ChG;
      ChG: r = ChC;
      default: r = ChN;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/pmc_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module pmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ hw/rtl/palindrome_mismatch_counter_core.sv @@
// Palindrome mismatch counter: buffers a sequence and counts reverse-complement mismatches.
//
// Input channel s_axis: one ASCII character per beat in tdata[7:0]; tlast marks the
// final character of a sequence. Characters beyond MAX_LEN are dropped and flagged.
// Output channel m_axis: one beat per sequence, mismatch count in tdata[5:0] and the
// overflow flag in tuser[0].
// Characters are stored in a single RAM, and s_axis stays ready throughout loading.
// After the last beat a compare pass reads one pair per cycle through the two RAM read
// ports, position i against position n-1-i, for floor(n/2) pairs. Once the last read
// data are checked, the state moves to done, and the count enters the output register
// when that is free; s_axis is held not ready meanwhile. The count saturates at 63.
// The output beat sits in a register: while it waits, the next sequence loads. A new
// pass finishing before the previous beat is taken waits for the receiver.
// Reset clears the length, the overflow flag, the state and the output valid; the
// sequence RAM is not cleared, as only entries written in the current sequence are read.
module palindrome_mismatch_counter_core #(
  parameter int unsigned MAX_LEN = pmc_pkg::MaxLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] nucleotide
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] mismatches, [7:6] zero
  output logic       m_axis_tuser    // [0] too_long
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = pmc_pkg::CntW;

  pmc_pkg::pmc_state_e state_q, state_d;

  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] n_q, n_d;
  logic          fin_ovf_q, fin_ovf_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          out_vld_q, out_vld_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic          out_ovf_q, out_ovf_d;

  logic          in_beat;
  logic          has_room;
  logic [LW-1:0] half;
  logic          pairs_left;
  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [LW-1:0] mirror;
  logic [7:0]    rdata_a, rdata_b;
  logic          pass_done;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign has_room   = (len_q < LW'(MAX_LEN));
  assign half       = n_q >> 1;
  assign pairs_left = (idx_q < half);
  assign pass_done  = !pairs_left && !rd_vld_q;
  assign out_free   = !out_vld_q || m_axis_tready;
  assign mirror     = n_q - LW'(1) - idx_q;
  assign raddr_a    = idx_q[AW-1:0];
  assign raddr_b    = mirror[AW-1:0];

  pmc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_seq_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (len_q[AW-1:0]),
    .wdata_i  (s_axis_tdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmc_pkg::ST_LOAD: begin
        if (in_beat && s_axis_tlast) state_d = pmc_pkg::ST_CMP;
      end
      pmc_pkg::ST_CMP: begin
        if (pass_done) state_d = pmc_pkg::ST_DONE;
      end
      pmc_pkg::ST_DONE: begin
        if (out_free) state_d = pmc_pkg::ST_LOAD;
      end
      default: state_d = pmc_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    case (state_q)
      pmc_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        ram_we        = in_beat && has_room;
      end
      pmc_pkg::ST_CMP:  s_axis_tready = 1'b0;
      pmc_pkg::ST_DONE: s_axis_tready = 1'b0;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    len_d     = len_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    fin_ovf_d = fin_ovf_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_cnt_d = out_cnt_q;
    out_ovf_d = out_ovf_q;

    if (state_q == pmc_pkg::ST_LOAD && in_beat) begin
      if (has_room) len_d = len_q + LW'(1);
      else          ovf_d = 1'b1;
      if (s_axis_tlast) begin
        // latch the finished sequence and rearm for the next one
        n_d       = has_room ? len_q + LW'(1) : len_q;
        fin_ovf_d = !has_room || ovf_q;
        len_d     = '0;
        ovf_d     = 1'b0;
        idx_d     = '0;
        cnt_d     = '0;
      end
    end

    if (state_q == pmc_pkg::ST_CMP) begin
      if (pairs_left) begin
        idx_d    = idx_q + LW'(1);
        rd_vld_d = 1'b1;
      end
      if (rd_vld_q && (rdata_a != pmc_pkg::base_pair(rdata_b))
          && (cnt_q != pmc_pkg::CntMax)) begin
        cnt_d = cnt_q + CW'(1);
      end
    end

    if (state_q == pmc_pkg::ST_DONE && out_free) begin
      out_vld_d = 1'b1;
      out_cnt_d = cnt_q;
      out_ovf_d = fin_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pmc_pkg::ST_LOAD;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    fin_ovf_q <= fin_ovf_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8 - CW){1'b0}}, out_cnt_q};
  assign m_axis_tuser  = out_ovf_q;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_LEN))
    else $error("stored length beyond buffer size");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pmc_pkg::ST_CMP) |-> (idx_q <= half))
    else $error("compare index ran past half length");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pmc_pkg::ST_CMP) |-> ({{LW{1'b0}}, cnt_q} <= {{CW{1'b0}}, idx_q}))
    else $error("mismatch count exceeds pairs read");

  a_rd_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == pmc_pkg::ST_CMP))
    else $error("read data returned outside compare pass");

  a_load_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast) |=> (state_q == pmc_pkg::ST_CMP && len_q == '0 && !ovf_q))
    else $error("last beat did not start compare pass");
`endif

endmodule
